FILE: src/assert_macros.svh
// assertion macros shared by the timestamp corrector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/mtc_pkg.sv
// types, codes and helper functions of the media timestamp corrector
`default_nettype none

package mtc_pkg;

  localparam logic [1:0] MODE_SIMPLE = 2'd0;
  localparam logic [1:0] MODE_MIDDLE = 2'd1;
  localparam logic [1:0] MODE_HIGH   = 2'd2;
  localparam logic [1:0] MODE_PASS   = 2'd3;

  localparam logic [1:0] MEDIA_AUDIO = 2'd1;
  localparam logic [1:0] MEDIA_VIDEO = 2'd2;

  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_FIXED_STEPS = 2'd1;
  localparam logic [1:0] REG_VIDEO_STEP  = 2'd2;
  localparam logic [1:0] REG_AUDIO_STEP  = 2'd3;

  localparam logic [63:0] WIN_HALF   = 64'd1000;
  localparam logic [63:0] WIN_SPAN   = 64'd2000;
  localparam logic [63:0] JUMP_STEP  = 64'd10;
  localparam logic [63:0] LEARN_SPAN = 64'd999;
  localparam logic [63:0] NO_OUT     = '1;

  typedef struct packed {
    logic [63:0] dts;
    logic [1:0]  media_type;
    logic        seq_header;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        fixed_steps;
    logic [31:0] video_step;
    logic [31:0] audio_step;
  } cfg_t;

  // signed value within [-1000, 1000]
  function automatic logic in_window(input logic [63:0] d);
    logic [63:0] s;
    s = d + WIN_HALF;
    return s <= WIN_SPAN;
  endfunction

  function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] clamp_neg(input logic [63:0] v);
    return v[63] ? 64'd0 : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/mtc_ifs.sv
// request and result channel interfaces of the media timestamp corrector
`default_nettype none

interface mtc_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] dts;
  logic        [1:0]  media_type;
  logic               seq_header;

  modport source (output valid, output dts, output media_type, output seq_header,
                  input ready);
  modport sink (input valid, input dts, input media_type, input seq_header,
                output ready);
endinterface

interface mtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] corrected_ts;

  modport source (output valid, output corrected_ts, input ready);
  modport sink (input valid, input corrected_ts, output ready);
endinterface

`default_nettype wire

FILE: src/mtc_in_reg.sv
// input register stage holding one request ahead of the correction logic
`default_nettype none

module mtc_in_reg (
  input  logic          clk,
  input  logic          rst,
  mtc_in_if.sink        pkt,
  input  logic          out_free,
  output logic          item_v,
  output mtc_pkg::item_t item,
  output logic          fire
);
  import mtc_pkg::*;

  logic take;

  assign fire      = item_v && out_free;
  assign pkt.ready = !item_v || out_free;
  assign take      = pkt.valid && pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (take) begin
      item_v <= 1'b1;
    end else if (fire) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.dts        <= pkt.dts;
      item.media_type <= pkt.media_type;
      item.seq_header <= pkt.seq_header;
    end
  end

endmodule

`default_nettype wire

FILE: src/mtc_engine.sv
// correction state and single-pass timestamp correction for all modes
`default_nettype none

`include "assert_macros.svh"

module mtc_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  mtc_pkg::item_t item,
  input  mtc_pkg::cfg_t  cfg,
  output logic [63:0]    result
);
  import mtc_pkg::*;

  logic [63:0] simple_prev_raw, simple_prev_raw_next;
  logic [63:0] simple_prev_out, simple_prev_out_next;
  logic [63:0] middle_prev_raw, middle_prev_raw_next;
  logic [63:0] middle_prev_out, middle_prev_out_next;
  logic [63:0] video_clock, video_clock_next;
  logic [63:0] audio_clock, audio_clock_next;
  logic [63:0] video_learned_step, video_learned_step_next;
  logic [63:0] audio_learned_step, audio_learned_step_next;
  logic [63:0] video_prev_raw, video_prev_raw_next;
  logic [63:0] audio_prev_raw, audio_prev_raw_next;
  logic        video_first, video_first_next;
  logic        audio_first, audio_first_next;

  logic [63:0] ts;
  logic [63:0] latest;
  logic        video_pkt;
  logic        audio_pkt;

  logic [63:0] trk_clk;
  logic [63:0] trk_learned;
  logic [63:0] trk_prev_raw;
  logic        trk_first;
  logic [63:0] trk_fv;
  logic [63:0] trk_delta;
  logic        trk_win;
  logic [63:0] trk_ori;
  logic        trk_learn_ok;
  logic [63:0] sum_fixed;
  logic [63:0] sum_old;
  logic [63:0] sum_ori;
  logic [63:0] trk_c1;
  logic [63:0] trk_c2;
  logic [63:0] trk_learned_new;
  logic [63:0] trk_seq_ts;
  logic [63:0] simple_delta;
  logic [63:0] middle_delta;

  assign ts        = clamp_neg(item.dts);
  assign latest    = smax(audio_clock, video_clock);
  assign video_pkt = item.media_type == MEDIA_VIDEO;
  assign audio_pkt = item.media_type == MEDIA_AUDIO;

  // high mode: one tracker datapath shared by audio and video, each with its own clock
  always_comb begin
    trk_clk      = video_pkt ? video_clock : audio_clock;
    trk_learned  = video_pkt ? video_learned_step : audio_learned_step;
    trk_prev_raw = video_pkt ? video_prev_raw : audio_prev_raw;
    trk_first    = video_pkt ? video_first : audio_first;
    trk_fv       = video_pkt ? sext32(cfg.video_step) : sext32(cfg.audio_step);

    trk_delta    = item.dts - trk_clk;
    trk_win      = in_window(trk_delta);
    trk_ori      = item.dts - trk_prev_raw;
    trk_learn_ok = !cfg.fixed_steps && ((trk_ori - 64'd1) < LEARN_SPAN);

    sum_fixed = trk_clk + trk_fv;
    sum_old   = trk_clk + trk_learned;
    sum_ori   = trk_clk + item.dts - trk_prev_raw;

    priority if (cfg.fixed_steps) begin
      trk_c1 = (trk_win && trk_first) ? 64'd0 : sum_fixed;
    end else if (trk_learn_ok) begin
      trk_c1 = (trk_win && trk_first) ? 64'd0 : sum_ori;
    end else if (!trk_win) begin
      trk_c1 = sum_old;
    end else begin
      trk_c1 = trk_first ? 64'd0 : item.dts;
    end

    priority if (cfg.fixed_steps) begin
      trk_learned_new = trk_learned;
    end else if (trk_learn_ok) begin
      trk_learned_new = trk_ori;
    end else if (trk_win) begin
      trk_learned_new = trk_delta;
    end else begin
      trk_learned_new = trk_learned;
    end

    trk_c2     = in_window(trk_c1 - latest) ? trk_c1 : latest;
    trk_seq_ts = trk_first ? 64'd0 : (cfg.fixed_steps ? sum_fixed : sum_old);
  end

  always_comb begin
    simple_prev_raw_next    = simple_prev_raw;
    simple_prev_out_next    = simple_prev_out;
    middle_prev_raw_next    = middle_prev_raw;
    middle_prev_out_next    = middle_prev_out;
    video_clock_next        = video_clock;
    audio_clock_next        = audio_clock;
    video_learned_step_next = video_learned_step;
    audio_learned_step_next = audio_learned_step;
    video_prev_raw_next     = video_prev_raw;
    audio_prev_raw_next     = audio_prev_raw;
    video_first_next        = video_first;
    audio_first_next        = audio_first;
    result                  = item.dts;
    simple_delta            = ts - simple_prev_raw;
    middle_delta            = ts - middle_prev_raw;

    unique case (cfg.mode)
      MODE_SIMPLE: begin
        if (item.seq_header) begin
          simple_prev_raw_next = ts;
          result               = ts;
        end else begin
          if (simple_prev_out != NO_OUT && !in_window(simple_delta)) begin
            simple_prev_out_next = simple_prev_out + JUMP_STEP;
          end else begin
            simple_prev_out_next = ts;
          end
          simple_prev_raw_next = ts;
          result               = simple_prev_out_next;
        end
      end
      MODE_MIDDLE: begin
        if (item.seq_header) begin
          if (middle_prev_out == NO_OUT) begin
            result = 64'd0;
          end else begin
            middle_prev_raw_next = ts;
            result               = middle_prev_out;
          end
        end else if (middle_prev_out == NO_OUT) begin
          middle_prev_out_next = 64'd0;
          middle_prev_raw_next = 64'd0;
          result               = 64'd0;
        end else begin
          if (in_window(middle_delta)) begin
            middle_prev_out_next = middle_prev_out + ts - middle_prev_raw;
          end else begin
            middle_prev_out_next = middle_prev_out + JUMP_STEP;
          end
          middle_prev_raw_next = ts;
          result               = middle_prev_out_next;
        end
      end
      MODE_HIGH: begin
        if (!video_pkt && !audio_pkt) begin
          result = 64'd0;
        end else if (item.seq_header) begin
          result = trk_seq_ts;
        end else begin
          result = trk_c2;
          if (video_pkt) begin
            video_clock_next        = trk_c2;
            video_learned_step_next = trk_learned_new;
            video_prev_raw_next     = item.dts;
            video_first_next        = 1'b0;
          end else begin
            audio_clock_next        = trk_c2;
            audio_learned_step_next = trk_learned_new;
            audio_prev_raw_next     = item.dts;
            audio_first_next        = 1'b0;
          end
        end
      end
      MODE_PASS: begin
        result = item.dts;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      simple_prev_raw    <= 64'd0;
      simple_prev_out    <= NO_OUT;
      middle_prev_raw    <= 64'd0;
      middle_prev_out    <= NO_OUT;
      video_clock        <= 64'd0;
      audio_clock        <= 64'd0;
      video_learned_step <= 64'd0;
      audio_learned_step <= 64'd0;
      video_prev_raw     <= 64'd0;
      audio_prev_raw     <= 64'd0;
      video_first        <= 1'b1;
      audio_first        <= 1'b1;
    end else if (fire) begin
      simple_prev_raw    <= simple_prev_raw_next;
      simple_prev_out    <= simple_prev_out_next;
      middle_prev_raw    <= middle_prev_raw_next;
      middle_prev_out    <= middle_prev_out_next;
      video_clock        <= video_clock_next;
      audio_clock        <= audio_clock_next;
      video_learned_step <= video_learned_step_next;
      audio_learned_step <= audio_learned_step_next;
      video_prev_raw     <= video_prev_raw_next;
      audio_prev_raw     <= audio_prev_raw_next;
      video_first        <= video_first_next;
      audio_first        <= audio_first_next;
    end
  end

  `ASSERT_NEXT(a_state_hold, clk, rst, !fire, $stable(video_clock) && $stable(middle_prev_out), "state changed without a request")
  `ASSERT_NEXT(a_video_used, clk, rst, fire && cfg.mode == MODE_HIGH && video_pkt && !item.seq_header, !video_first, "video clock still marked unused")
  `ASSERT_NEXT(a_middle_start, clk, rst, fire && cfg.mode == MODE_MIDDLE && !item.seq_header && middle_prev_out == NO_OUT, middle_prev_out == 64'd0 && middle_prev_raw == 64'd0, "middle accumulator did not start at zero")

endmodule

`default_nettype wire

FILE: src/mtc_out_reg.sv
// result register driving the result channel
`default_nettype none

module mtc_out_reg (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [63:0] data,
  mtc_out_if.source   res,
  output logic        out_free
);
  import mtc_pkg::*;

  logic        valid;
  logic [63:0] ts;

  assign out_free         = !valid || res.ready;
  assign res.valid        = valid;
  assign res.corrected_ts = ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ts <= data;
    end
  end

endmodule

`default_nettype wire

FILE: src/media_timestamp_corrector.sv
// media timestamp corrector top level: config registers and stage wiring
//
//   channel  role    payload
//   pkt      sink    dts, media_type, seq_header
//   res      source  corrected_ts
//   cfg_*    write   cfg_we, cfg_index, cfg_data
//
// request to result: input register, then correction logic into the result register;
// the mode state is updated in the same cycle as the result register is loaded
// one request per cycle while res.ready holds, set by the engine state feedback
// synchronous reset clears both stages and restores the mode state
// a stalled result holds the input register full; pkt.ready drops only then
`default_nettype none

`include "assert_macros.svh"

module media_timestamp_corrector (
  input  logic        clk,
  input  logic        rst,
  mtc_in_if.sink      pkt,
  mtc_out_if.source   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mtc_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_v;
  logic  fire;
  logic  out_free;
  logic [63:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_MIDDLE;
      cfg.fixed_steps <= 1'b0;
      cfg.video_step  <= 32'd0;
      cfg.audio_step  <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        cfg.mode        <= cfg_data[1:0];
        REG_FIXED_STEPS: cfg.fixed_steps <= cfg_data[0];
        REG_VIDEO_STEP:  cfg.video_step  <= cfg_data;
        REG_AUDIO_STEP:  cfg.audio_step  <= cfg_data;
      endcase
    end
  end

  mtc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt),
    .out_free (out_free),
    .item_v   (item_v),
    .item     (item),
    .fire     (fire)
  );

  mtc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  mtc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .data     (result),
    .res      (res),
    .out_free (out_free)
  );

  `ASSERT_NEXT(a_item_held, clk, rst, item_v && !out_free, item_v, "pending request dropped while result stalled")
  `ASSERT_NEXT(a_result_loaded, clk, rst, fire, res.valid, "processed request produced no result")

endmodule

`default_nettype wire

FILE: bench/media_timestamp_corrector_test.sv
// self-checking testbench of the media timestamp corrector
`default_nettype none

module media_timestamp_corrector_test;
  import mtc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 154;
  localparam int RANDOM_PHASES = 12;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  mtc_in_if  pkt_if ();
  mtc_out_if res_if ();

  media_timestamp_corrector dut (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  item_t       pending [$];
  logic [63:0] expected_ts [$];
  item_t       on_bus;
  logic [63:0] want_ts;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count;
  int          result_count;
  int          cycle_count;
  logic [63:0] stream_ts [4];

  // shadow configuration
  logic [1:0]  sh_mode;
  logic        sh_fixed;
  logic [31:0] sh_vstep;
  logic [31:0] sh_astep;

  // shadow correction state, channel 0 audio, channel 1 video
  logic [63:0] smp_raw, smp_out, mid_raw, mid_out;
  logic [63:0] hi_clock [2];
  logic [63:0] hi_learn [2];
  logic [63:0] hi_raw [2];
  logic        hi_first [2];

  function automatic logic near(input logic [63:0] d);
    logic [63:0] s;
    s = d + WIN_HALF;
    return s <= WIN_SPAN;
  endfunction

  function automatic logic [63:0] widen_step(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] advance_clock(input int ch, input logic [63:0] dts,
                                                input logic [63:0] latest,
                                                input logic [63:0] fstep);
    logic [63:0] dlt;
    logic [63:0] ori;
    logic        learned_now;
    learned_now = 1'b0;
    dlt = dts - hi_clock[ch];
    if (!sh_fixed) begin
      ori = dts - hi_raw[ch];
      if (ori - 64'd1 < LEARN_SPAN) begin
        hi_learn[ch] = ori;
        learned_now = 1'b1;
      end
    end
    hi_raw[ch] = dts;
    if (!near(dlt)) begin
      hi_clock[ch] = hi_clock[ch] + (sh_fixed ? fstep : hi_learn[ch]);
    end else begin
      if (!sh_fixed && !learned_now) hi_learn[ch] = dlt;
      if (hi_first[ch]) hi_clock[ch] = 64'd0;
      else hi_clock[ch] = hi_clock[ch] + (sh_fixed ? fstep : hi_learn[ch]);
    end
    if (!near(hi_clock[ch] - latest)) hi_clock[ch] = latest;
    hi_first[ch] = 1'b0;
    return hi_clock[ch];
  endfunction

  function automatic logic [63:0] correct_ts(input item_t it);
    logic [63:0] ts;
    logic [63:0] dlt;
    logic [63:0] latest;
    logic [63:0] fstep;
    logic [63:0] r;
    int          ch;
    ts = it.dts[63] ? 64'd0 : it.dts;
    r = 64'd0;
    case (sh_mode)
      MODE_SIMPLE: begin
        if (it.seq_header) begin
          smp_raw = ts;
          r = ts;
        end else begin
          if (smp_out != NO_OUT && !near(ts - smp_raw)) smp_out = smp_out + JUMP_STEP;
          else smp_out = ts;
          smp_raw = ts;
          r = smp_out;
        end
      end
      MODE_MIDDLE: begin
        if (it.seq_header) begin
          if (mid_out == NO_OUT) begin
            r = 64'd0;
          end else begin
            mid_raw = ts;
            r = mid_out;
          end
        end else if (mid_out == NO_OUT) begin
          mid_out = 64'd0;
          mid_raw = 64'd0;
          r = 64'd0;
        end else begin
          dlt = ts - mid_raw;
          mid_out = mid_out + (near(dlt) ? dlt : JUMP_STEP);
          mid_raw = ts;
          r = mid_out;
        end
      end
      MODE_HIGH: begin
        latest = ($signed(hi_clock[0]) >= $signed(hi_clock[1])) ? hi_clock[0] : hi_clock[1];
        if (it.media_type == MEDIA_VIDEO || it.media_type == MEDIA_AUDIO) begin
          ch = (it.media_type == MEDIA_VIDEO) ? 1 : 0;
          fstep = widen_step(ch == 1 ? sh_vstep : sh_astep);
          if (it.seq_header)
            r = hi_first[ch] ? 64'd0 : hi_clock[ch] + (sh_fixed ? fstep : hi_learn[ch]);
          else
            r = advance_clock(ch, it.dts, latest, fstep);
        end
      end
      default: r = it.dts;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on result %0d: %s, corrected_ts %h, predicted %h",
             result_count, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MODE:        sh_mode = val[1:0];
      REG_FIXED_STEPS: sh_fixed = val[0];
      REG_VIDEO_STEP:  sh_vstep = val;
      default:         sh_astep = val;
    endcase
  endtask

  task automatic set_config(input logic [1:0] md, input logic fx,
                            input logic [31:0] vs, input logic [31:0] as_val);
    write_reg(REG_MODE, {30'd0, md});
    write_reg(REG_FIXED_STEPS, {31'd0, fx});
    write_reg(REG_VIDEO_STEP, vs);
    write_reg(REG_AUDIO_STEP, as_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_item(input logic [63:0] d, input logic [1:0] mt, input logic sq);
    item_t it;
    it.dts        = d;
    it.media_type = mt;
    it.seq_header = sq;
    pending.push_back(it);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || pkt_if.valid || expected_ts.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_random_item();
    logic [1:0]  mt;
    logic [63:0] d;
    logic [63:0] j;
    int          pick;
    logic        follow;
    mt = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    d = stream_ts[mt];
    follow = 1'b1;
    if (pick < 65) begin
      d = d + $urandom_range(1, 60);
    end else if (pick < 72) begin
      d = d - $urandom_range(0, 30);
    end else if (pick < 78) begin
      j = $urandom_range(1001, 200000);
      d = $urandom_range(0, 1) ? d + j : d - j;
    end else if (pick < 84) begin
      j = $urandom_range(998, 1002);
      d = $urandom_range(0, 1) ? d + j : d - j;
    end else if (pick < 88) begin
      d = stream_ts[3 - mt] + $urandom_range(0, 40);
    end else if (pick < 93) begin
      d = {$urandom, $urandom};
      follow = 1'b0;
    end else if (pick < 97) begin
      d = 64'd0 - $urandom_range(1, 3000);
      follow = 1'b0;
    end else begin
      case ($urandom_range(0, 3))
        0:       d = 64'h7fff_ffff_ffff_ffff;
        1:       d = 64'h8000_0000_0000_0000;
        2:       d = '1;
        default: d = 64'd0;
      endcase
      follow = 1'b0;
    end
    if (follow) stream_ts[mt] = d;
    add_item(d, mt, $urandom_range(0, 19) == 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      pkt_if.valid <= 1'b0;
    end else begin
      if (pkt_if.valid && pkt_if.ready) expected_ts.push_back(correct_ts(on_bus));
      if (!pkt_if.valid || pkt_if.ready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending.pop_front();
          pkt_if.valid      <= 1'b1;
          pkt_if.dts        <= on_bus.dts;
          pkt_if.media_type <= on_bus.media_type;
          pkt_if.seq_header <= on_bus.seq_header;
        end else begin
          pkt_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (res_if.valid && res_if.ready) begin
        if (expected_ts.size() == 0) begin
          report_mismatch("no request pending", res_if.corrected_ts, 'x);
        end else begin
          want_ts = expected_ts.pop_front();
          if (res_if.corrected_ts !== want_ts)
            report_mismatch("wrong timestamp", res_if.corrected_ts, want_ts);
        end
        result_count++;
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("media_timestamp_corrector test failed");
    $finish;
  end

  initial begin
    logic [1:0]  md;
    logic        fx;
    logic [31:0] vs;
    logic [31:0] as_val;
    pkt_if.valid      = 1'b0;
    pkt_if.dts        = '0;
    pkt_if.media_type = '0;
    pkt_if.seq_header = 1'b0;
    res_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    error_count       = 0;
    result_count      = 0;
    for (int i = 0; i < 4; i++) stream_ts[i] = 64'd0;
    sh_mode  = MODE_MIDDLE;
    sh_fixed = 1'b0;
    sh_vstep = '0;
    sh_astep = '0;
    smp_raw  = 64'd0;
    smp_out  = NO_OUT;
    mid_raw  = 64'd0;
    mid_out  = NO_OUT;
    for (int i = 0; i < 2; i++) begin
      hi_clock[i] = 64'd0;
      hi_learn[i] = 64'd0;
      hi_raw[i]   = 64'd0;
      hi_first[i] = 1'b1;
    end
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // middle mode from reset: header before first packet, first packet, jumps
    add_item(64'd100, MEDIA_VIDEO, 1'b1);
    add_item(64'd5000, MEDIA_VIDEO, 1'b0);
    add_item(64'd5040, MEDIA_VIDEO, 1'b0);
    add_item(64'd200000, MEDIA_AUDIO, 1'b0);
    add_item(-64'sd5, MEDIA_AUDIO, 1'b0);
    add_item(64'd300, MEDIA_VIDEO, 1'b1);
    drain();

    set_config(MODE_SIMPLE, 1'b0, 32'd0, 32'd0);
    add_item(-64'sd7, MEDIA_VIDEO, 1'b1);
    add_item(64'd1000, MEDIA_VIDEO, 1'b0);
    add_item(64'd2001, MEDIA_VIDEO, 1'b0);
    add_item(64'h7fff_ffff_ffff_ffff, MEDIA_AUDIO, 1'b0);
    add_item(64'h8000_0000_0000_0000, MEDIA_AUDIO, 1'b0);
    drain();

    set_config(MODE_HIGH, 1'b0, 32'd0, 32'd0);
    add_item(64'd10, MEDIA_VIDEO, 1'b1);
    add_item(64'd77, 2'd0, 1'b0);
    add_item(64'd88, 2'd3, 1'b1);
    add_item(64'd0, MEDIA_VIDEO, 1'b0);
    add_item(64'd40, MEDIA_VIDEO, 1'b0);
    add_item(64'd23, MEDIA_AUDIO, 1'b0);
    add_item(64'd46, MEDIA_AUDIO, 1'b0);
    add_item(64'd80, MEDIA_VIDEO, 1'b1);
    add_item(64'd900000, MEDIA_AUDIO, 1'b0);
    add_item(-64'sd50, MEDIA_VIDEO, 1'b0);
    drain();

    set_config(MODE_HIGH, 1'b1, 32'h7fff_ffff, 32'h8000_0000);
    add_item(64'd100, MEDIA_VIDEO, 1'b0);
    add_item(64'd110, MEDIA_AUDIO, 1'b0);
    drain();

    set_config(MODE_PASS, 1'b0, 32'd0, 32'd0);
    add_item(64'h8000_0000_0000_0000, MEDIA_VIDEO, 1'b0);
    add_item('1, 2'd3, 1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      fx = 1'b0;
      vs = $urandom;
      as_val = $urandom;
      case (p)
        0, 6, 10: md = MODE_MIDDLE;
        1, 8:     md = MODE_SIMPLE;
        4:        md = MODE_PASS;
        3: begin
          md = MODE_HIGH;
          fx = 1'b1;
          vs = 32'd33;
          as_val = 32'd23;
        end
        5: begin
          md = MODE_HIGH;
          fx = 1'b1;
          vs = 32'h7fff_ffff;
          as_val = 32'h8000_0000;
        end
        9: begin
          md = MODE_HIGH;
          fx = 1'b1;
          vs = $urandom_range(0, 2000) - 1000;
          as_val = $urandom_range(0, 2000) - 1000;
        end
        default: md = MODE_HIGH;
      endcase
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_config(md, fx, vs, as_val);
      case (p % 4)
        1: send_idle_pct = 79;
        2: recv_stall_pct = 79;
        3: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) add_random_item();
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (expected_ts.size() != 0) report_mismatch("result missing", 'x, expected_ts[0]);
    if (error_count == 0) begin
      $display("media_timestamp_corrector test passed");
    end else begin
      $display("media_timestamp_corrector test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
